### rtl/pvb_pkg.sv
// Shared types and codes for the point voxel binning block.
`timescale 1ns / 1ps

package pvb_pkg;

   // One input beat
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               point_valid;
      logic [31:0]        point_age;
      logic [7:0]         cell_x;
      logic [7:0]         cell_y;
      logic [7:0]         cell_z;
   } pvb_req_type;

   // One result beat
   typedef struct packed {
      logic        in_grid;
      logic [11:0] cell_index;
      logic [15:0] cell_count;
   } pvb_rsp_type;

   // Command to the shared multiply unit: prod = (op_a + op_add) * op_b
   typedef struct packed {
      logic        en;
      logic [31:0] op_a;
      logic [7:0]  op_add;
      logic [31:0] op_b;
   } pvb_mul_req_type;

   // Item modes
   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_MIN_X  = 3'd0;
   localparam logic [2:0] CSR_MIN_Y  = 3'd1;
   localparam logic [2:0] CSR_MIN_Z  = 3'd2;
   localparam logic [2:0] CSR_INV_X  = 3'd3;
   localparam logic [2:0] CSR_INV_Y  = 3'd4;
   localparam logic [2:0] CSR_INV_Z  = 3'd5;
   localparam logic [2:0] CSR_DIMS   = 3'd6;
   localparam logic [2:0] CSR_EXPIRE = 3'd7;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [31:0] INV_RESET = 32'd65536;

endpackage

### rtl/point_voxel_binning.sv
// Top level of the point voxel binning block: sequencer, registers and count store.
`timescale 1ns / 1ps

// Bins 3D Q16.16 points into a grid of saturating 16-bit hit counters held in one
// RAM of N_CELLS entries with one write and one read port. Items are taken one at a
// time: req_ready is high only while the sequencer idles, and a finished result waits
// in an output register so the next item can be accepted while it does. An add-point
// item steps through a subtract, multiply and range check per axis, two multiplies and
// an add to form the linear index, then a RAM read, a write-back and the hand-off to
// the output register; a dropped point skips the rest up to the hand-off. A read item
// runs the index, read and hand-off steps; a clear item sweeps the RAM one entry per
// cycle. All multiplies share one 32x32 multiplier. After reset the block runs the
// same sweep with req_ready low; configuration writes are taken at any time and
// csr_ready stays high.
module point_voxel_binning
   import pvb_pkg::*;
#(
   parameter int N_CELLS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pvb_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pvb_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(N_CELLS);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIFF, ST_MUL, ST_CHK, ST_LIN1, ST_LIN2, ST_LIN3,
      ST_READ, ST_UPD, ST_DONE
   } state_type;

   // Configuration registers
   logic [31:0] min_ff [3];
   logic [31:0] inv_ff [3];
   logic [23:0] dims_ff;
   logic [31:0] expire_ff;

   // Sequencer and datapath registers
   state_type   state_ff;
   pvb_req_type req_ff;
   logic [1:0]  axis_ff;
   logic [31:0] diff_ff;
   logic [7:0]  c_ff [3];
   logic [24:0] lin_ff;
   pvb_rsp_type res_ff;
   pvb_rsp_type rsp_ff;
   logic        rsp_valid_ff;
   logic [AW-1:0] clr_addr_ff;
   logic        boot_ff;

   // Datapath signals
   logic [31:0] pos_sel;
   logic [7:0]  dim_sel;
   logic [32:0] diff_in;
   logic [24:0] lin_in;
   logic [15:0] count_in;
   logic        expired;
   logic        rsp_free;
   logic [63:0] prod;
   pvb_mul_req_type mul_cmd;
   logic        ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [15:0] ram_wr_data;
   logic        ram_rd_en;
   logic [15:0] ram_rd_data;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff[0] <= '0;
         min_ff[1] <= '0;
         min_ff[2] <= '0;
         inv_ff[0] <= INV_RESET;
         inv_ff[1] <= INV_RESET;
         inv_ff[2] <= INV_RESET;
         dims_ff   <= '0;
         expire_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_X:  min_ff[0] <= csr_wdata;
            CSR_MIN_Y:  min_ff[1] <= csr_wdata;
            CSR_MIN_Z:  min_ff[2] <= csr_wdata;
            CSR_INV_X:  inv_ff[0] <= csr_wdata;
            CSR_INV_Y:  inv_ff[1] <= csr_wdata;
            CSR_INV_Z:  inv_ff[2] <= csr_wdata;
            CSR_DIMS:   dims_ff   <= csr_wdata[23:0];
            CSR_EXPIRE: expire_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // Select the current axis
   always_comb begin
      case (axis_ff)
         2'd0:    pos_sel = req_ff.pos_x;
         2'd1:    pos_sel = req_ff.pos_y;
         default: pos_sel = req_ff.pos_z;
      endcase
   end

   assign dim_sel  = dims_ff[8*axis_ff +: 8];
   assign diff_in  = {pos_sel[31], pos_sel} - {min_ff[axis_ff][31], min_ff[axis_ff]};
   assign lin_in   = prod[24:0] + {17'd0, c_ff[2]};
   assign count_in = (ram_rd_data == COUNT_MAX) ? COUNT_MAX : ram_rd_data + 16'd1;
   assign expired  = (expire_ff != 32'd0) && (req_data.point_age > expire_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Drive the shared multiplier
   always_comb begin
      mul_cmd = '0;
      case (state_ff)
         ST_MUL: begin
            mul_cmd.en   = 1'b1;
            mul_cmd.op_a = diff_ff;
            mul_cmd.op_b = inv_ff[axis_ff];
         end
         ST_LIN1: begin
            mul_cmd.en   = 1'b1;
            mul_cmd.op_a = {24'd0, c_ff[0]};
            mul_cmd.op_b = {24'd0, dims_ff[15:8]};
         end
         ST_LIN2: begin
            mul_cmd.en     = 1'b1;
            mul_cmd.op_a   = prod[31:0];
            mul_cmd.op_add = c_ff[1];
            mul_cmd.op_b   = {24'd0, dims_ff[23:16]};
         end
         default: ;
      endcase
   end

   pvb_mul u_mul (
      .clock (clock),
      .cmd   (mul_cmd),
      .prod  (prod)
   );

   // Count store ports: sweep writes zero, update writes the bumped count
   assign ram_wr_en   = (state_ff == ST_CLEAR) ||
                        (state_ff == ST_UPD && req_ff.mode == MODE_ADD);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : lin_ff[AW-1:0];
   assign ram_wr_data = (state_ff == ST_CLEAR) ? 16'd0 : count_in;
   assign ram_rd_en   = (state_ff == ST_READ);

   pvb_ram #(
      .WIDTH (16),
      .DEPTH (N_CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (lin_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
         boot_ff      <= 1'b1;
      end else begin
         // raise the result beat on hand-off, drop it once taken
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (clr_addr_ff == AW'(N_CELLS - 1)) begin
                  state_ff <= boot_ff ? ST_IDLE : ST_DONE;
                  boot_ff  <= 1'b0;
               end else begin
                  clr_addr_ff <= clr_addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff  <= req_data;
                  res_ff  <= '0;
                  axis_ff <= 2'd0;
                  case (req_data.mode)
                     MODE_ADD: begin
                        if (!req_data.point_valid || expired) begin
                           state_ff <= ST_DONE;
                        end else begin
                           state_ff <= ST_DIFF;
                        end
                     end
                     MODE_CLEAR: begin
                        clr_addr_ff <= '0;
                        state_ff    <= ST_CLEAR;
                     end
                     MODE_READ: begin
                        c_ff[0]  <= req_data.cell_x;
                        c_ff[1]  <= req_data.cell_y;
                        c_ff[2]  <= req_data.cell_z;
                        state_ff <= ST_LIN1;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_DIFF: begin
               // below the grid minimum drops the point
               if (diff_in[32]) begin
                  state_ff <= ST_DONE;
               end else begin
                  diff_ff  <= diff_in[31:0];
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               if (prod[63:32] >= {24'd0, dim_sel}) begin
                  state_ff <= ST_DONE;
               end else begin
                  c_ff[axis_ff] <= prod[39:32];
                  if (axis_ff == 2'd2) begin
                     state_ff <= ST_LIN1;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_DIFF;
                  end
               end
            end
            ST_LIN1: begin
               if (c_ff[0] >= dims_ff[7:0] || c_ff[1] >= dims_ff[15:8] ||
                   c_ff[2] >= dims_ff[23:16]) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_LIN2;
               end
            end
            ST_LIN2: begin
               state_ff <= ST_LIN3;
            end
            ST_LIN3: begin
               // beyond the store counts as outside
               lin_ff <= lin_in;
               if (lin_in >= 25'(N_CELLS)) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               res_ff.in_grid    <= 1'b1;
               res_ff.cell_index <= lin_ff[11:0];
               res_ff.cell_count <= (req_ff.mode == MODE_ADD) ? count_in : ram_rd_data;
               state_ff          <= ST_DONE;
            end
            ST_DONE: begin
               // hand the result to the output register when it is free
               if (rsp_free) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // No store write while the block takes a new item
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ram_wr_en)
      else $error("count store written while idle");

   // A miss carries zero index and count
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.in_grid) |->
         (rsp_data.cell_index == 12'd0 && rsp_data.cell_count == 16'd0))
      else $error("miss result with nonzero payload");

   // Reset starts the clearing sweep
   a_boot_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during clearing sweep after reset");
`endif

endmodule

### rtl/pvb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pvb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pvb_mul.sv
// Shared add-then-multiply unit with a registered 64-bit product.
`timescale 1ns / 1ps

module pvb_mul
   import pvb_pkg::*;
(
   input  logic            clock,
   input  pvb_mul_req_type cmd,
   output logic [63:0]     prod
);

   logic [31:0] sum_in;
   logic [63:0] prod_in;
   logic [63:0] prod_ff;

   // Pre-add the small addend, then one 32x32 multiply
   assign sum_in  = cmd.op_a + {24'd0, cmd.op_add};
   assign prod_in = {32'd0, sum_in} * {32'd0, cmd.op_b};

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
